FILE: design/fsehc_pkg.sv
// Shared constants for the force sensor contact unit: field widths,
// register indexes, filter weight limits and the millivolt reference.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fsehc_pkg;

    // Field widths of the stream beats and the configuration port
    localparam int SAMPLE_W    = 16;
    localparam int LEVEL_W     = 32;
    localparam int MV_W        = 12;
    localparam int THR_W       = 16;
    localparam int WEIGHT_W    = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTACT_THR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_THR = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT      = 2'd2;

    // Filter weight in Q1.16, 0x10000 is unity
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN     = 17'd1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = 17'd65536;
    localparam logic [WEIGHT_W-1:0] WEIGHT_DEFAULT = 17'd19661;

    // Converter reference in millivolts
    localparam logic [MV_W-1:0] VREF_MV = 12'd3300;

endpackage

`default_nettype wire

FILE: design/force_sensor_ema_hysteresis_contact_unit.sv
// Force sensor contact unit: exponential moving average over converter
// samples followed by a hysteresis contact detector. Uses fsehc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// ---------------------------------------------------------------------------
// Usage
//   Input stream (s_axis): one beat per converter sample, tdata[15:0] holds
//   raw_sample; only the low SAMPLE_BITS bits are used.
//   Output stream (m_axis): one beat per sample, carrying the filtered level
//   (Q16.16 by default), the level in millivolts, the contact flag and a
//   flag that marks a contact change on this sample.
//   Config port: i_cfg_we / i_cfg_index / i_cfg_wdata, write-only, takes
//   effect on the next sample. Index 0 contact threshold, 1 release
//   threshold, 2 filter weight (out-of-range weight writes load 0.3).
//   Write it only while no beat is in flight.
// Timing
//   Three register stages: filter update, contact update plus millivolt
//   product, then the millivolt divide into the output register. A sample
//   accepted into stage 1 moves through stage 2 into the output register.
//   One beat per cycle while m_axis is ready; the filter recurrence (two multiplies
//   and an add) closes in stage one, so it does not limit the rate below one per clock.
// Reset (synchronous, active low) clears the filter to "unseeded", the
//   contact flag to airborne, the thresholds to zero, the weight to 0.3 and
//   empties the pipeline.
// Stall: when m_axis is held off, the stages behind the output register
//   keep filling; s_axis tready drops only once all three stages are full.
// ---------------------------------------------------------------------------
module force_sensor_ema_hysteresis_contact_unit #(
    parameter int SAMPLE_BITS   = 16,   // 8..16
    parameter int FRACTION_BITS = 16    // 8..24, with SAMPLE_BITS + FRACTION_BITS <= 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // sample stream
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    input  wire logic [fsehc_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // [15:0] raw_sample
    // result stream
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // [31:0] filtered_level, [43:32] level_millivolts, [44] in_contact,
    // [45] contact_changed, [47:46] zero
    output logic [fsehc_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    // configuration writes
    input  wire logic                                i_cfg_we,
    input  wire logic [fsehc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [fsehc_pkg::WEIGHT_W-1:0]      i_cfg_wdata
);

    localparam int LW   = fsehc_pkg::LEVEL_W;
    localparam int WW   = fsehc_pkg::WEIGHT_W;
    localparam int MW   = fsehc_pkg::MV_W;
    localparam int TW   = fsehc_pkg::THR_W;
    localparam int WPW  = WW + SAMPLE_BITS;               // weight * sample
    localparam int AW   = WPW + FRACTION_BITS;            // weight * sample_fx
    localparam int BW   = WW + LW;                        // (1 - weight) * level
    localparam int SFW  = SAMPLE_BITS + FRACTION_BITS;    // sample in fixed point
    localparam int CW   = (TW + FRACTION_BITS > LW) ? TW + FRACTION_BITS : LW;
    localparam int PW   = LW + MW;                        // level * 3300
    localparam int QW   = PW - FRACTION_BITS;             // integer part of that
    localparam int EW   = QW + 1;                         // divide work width
    localparam logic [EW-1:0] FULL_SCALE   = EW'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [EW-1:0] FULL_SCALE_2 = EW'(((64'd1 << SAMPLE_BITS) - 64'd1) * 64'd2);

    // ---------------- configuration ----------------
    logic [TW-1:0] r_contact_thr;
    logic [TW-1:0] r_release_thr;
    logic [WW-1:0] r_weight;
    logic          n_weight_ok;

    always_comb begin
        n_weight_ok = i_cfg_wdata inside {[fsehc_pkg::WEIGHT_MIN:fsehc_pkg::WEIGHT_ONE]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_contact_thr <= '0;
            r_release_thr <= '0;
            r_weight      <= fsehc_pkg::WEIGHT_DEFAULT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fsehc_pkg::CFG_CONTACT_THR: begin
                    r_contact_thr <= i_cfg_wdata[TW-1:0];
                end
                fsehc_pkg::CFG_RELEASE_THR: begin
                    r_release_thr <= i_cfg_wdata[TW-1:0];
                end
                fsehc_pkg::CFG_WEIGHT: begin
                    r_weight <= n_weight_ok ? i_cfg_wdata : fsehc_pkg::WEIGHT_DEFAULT;
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;
    logic n_accept;
    logic n_ld2;
    logic n_ld3;

    assign n_ld3           = r_s2_valid && (!r_out_valid || i_m_axis_tready);
    assign n_ld2           = r_s1_valid && (!r_s2_valid || n_ld3);
    assign o_s_axis_tready = !r_s1_valid || n_ld2;
    assign n_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (n_accept) begin
                r_s1_valid <= 1'b1;
            end else if (n_ld2) begin
                r_s1_valid <= 1'b0;
            end
            if (n_ld2) begin
                r_s2_valid <= 1'b1;
            end else if (n_ld3) begin
                r_s2_valid <= 1'b0;
            end
            if (n_ld3) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- stage 1: filter update ----------------
    // r_filt is both the filter state and the stage 1 payload.
    logic [LW-1:0]          r_filt;
    logic [LW-1:0]          n_filt;
    logic [SAMPLE_BITS-1:0] n_sample;
    logic [WPW-1:0]         n_wprod;
    logic [AW-1:0]          n_a_full;
    logic [BW-1:0]          n_b_full;
    logic [SFW-1:0]         n_seed;

    always_comb begin
        n_sample = i_s_axis_tdata[SAMPLE_BITS-1:0];
        n_wprod  = WPW'(r_weight) * WPW'(n_sample);
        n_a_full = AW'(n_wprod) << FRACTION_BITS;
        n_b_full = BW'(fsehc_pkg::WEIGHT_ONE - r_weight) * BW'(r_filt);
        n_seed   = SFW'(n_sample) << FRACTION_BITS;
        if (r_filt == '0) begin
            // unseeded (or decayed to zero): load the sample directly
            n_filt = LW'(n_seed);
        end else begin
            n_filt = LW'(n_a_full >> 16) + LW'(n_b_full >> 16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= '0;
        end else if (n_accept) begin
            r_filt <= n_filt;
        end
    end

    // ---------------- stage 2: contact hysteresis, mV product ----------------
    logic          r_contact;
    logic          n_contact;
    logic [CW-1:0] n_level_ext;
    logic [PW-1:0] n_prod;
    logic [LW-1:0] r_s2_level;
    logic [QW-1:0] r_s2_q;
    logic          r_s2_contact;
    logic          r_s2_changed;

    always_comb begin
        n_level_ext = CW'(r_filt);
        if (r_contact) begin
            n_contact = !(n_level_ext <= (CW'(r_release_thr) << FRACTION_BITS));
        end else begin
            n_contact = n_level_ext >= (CW'(r_contact_thr) << FRACTION_BITS);
        end
        n_prod = PW'(r_filt) * PW'(fsehc_pkg::VREF_MV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_contact <= 1'b0;
        end else if (n_ld2) begin
            r_contact <= n_contact;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_ld2) begin
            r_s2_level   <= r_filt;
            r_s2_q       <= QW'(n_prod >> FRACTION_BITS);
            r_s2_contact <= n_contact;
            r_s2_changed <= n_contact != r_contact;
        end
    end

    // ---------------- stage 3: divide by full scale ----------------
    // q / (2^S - 1) estimated as (q + q>>S) >> S, which is low by at most
    // two; the remainder then picks the correction.
    logic [EW-1:0] n_est_sum;
    logic [EW-1:0] n_est;
    logic [EW-1:0] n_est_m;
    logic [EW-1:0] n_rem;
    logic [EW-1:0] n_quot;
    logic [MW-1:0] n_mv;

    always_comb begin
        n_est_sum = EW'(r_s2_q) + EW'(r_s2_q >> SAMPLE_BITS);
        n_est     = n_est_sum >> SAMPLE_BITS;
        n_est_m   = (n_est << SAMPLE_BITS) - n_est;
        n_rem     = EW'(r_s2_q) - n_est_m;
        if (n_rem >= FULL_SCALE_2) begin
            n_quot = n_est + EW'(2);
        end else if (n_rem >= FULL_SCALE) begin
            n_quot = n_est + EW'(1);
        end else begin
            n_quot = n_est;
        end
        if (n_quot > EW'(fsehc_pkg::VREF_MV)) begin
            n_mv = fsehc_pkg::VREF_MV;
        end else begin
            n_mv = MW'(n_quot);
        end
    end

    // ---------------- output register ----------------
    logic [LW-1:0] r_out_level;
    logic [MW-1:0] r_out_mv;
    logic          r_out_contact;
    logic          r_out_changed;

    always_ff @(posedge i_clk) begin
        if (n_ld3) begin
            r_out_level   <= r_s2_level;
            r_out_mv      <= n_mv;
            r_out_contact <= r_s2_contact;
            r_out_changed <= r_s2_changed;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_changed, r_out_contact, r_out_mv, r_out_level};

    // ---------------- assertions ----------------
    // Reset empties every stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !r_s2_valid && !r_out_valid))
        else $error("pipeline not empty after reset");

    // Filter state moves only with an accepted sample.
    a_filt_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !n_accept |=> $stable(r_filt))
        else $error("filter level changed without an accepted beat");

    // Divider output never exceeds the reference.
    a_mv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_mv <= fsehc_pkg::VREF_MV))
        else $error("millivolt result above reference");

    // A change flag always comes with a flipped contact state.
    a_change_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_ld2 |=> (r_s2_changed == (r_contact != $past(r_contact))))
        else $error("contact change flag inconsistent with state");

endmodule

`default_nettype wire
